[rtl/step_cadence_peak_counter_core_macros.svh]
// Assertion macros used by the step cadence checker.
`ifndef STEP_CADENCE_PEAK_COUNTER_CORE_MACROS_SVH
`define STEP_CADENCE_PEAK_COUNTER_CORE_MACROS_SVH

// same-cycle implication
`define SCPC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("step cadence check failed");

// next-cycle implication
`define SCPC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("step cadence check failed");

`endif

[rtl/scpc_pkg.sv]
// Shared types and constants of the step cadence peak counter.
`default_nettype none
package scpc_pkg;
   localparam int WINDOW_DEPTH_DEF = 200;
   localparam int SAMPLE_W = 16;
   localparam int DIFF_W = 17;
   localparam int FACTOR_W = 8;
   localparam int BPM_W = 16;
   localparam int TOTAL_W = 8;
   localparam int BPM_MAX = 65535;
   localparam int TOTAL_MAX = 255;
   localparam int QUEUE_DEPTH = 2;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 17;

   localparam logic [CSR_IDX_W-1:0] CSR_PEAK_THRESHOLD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BPM_PER_PEAK = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RUN_LOW_BPM = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RUN_HIGH_BPM = 2'd3;

   localparam logic signed [DIFF_W-1:0] PEAK_THRESHOLD_RST = 17'sd1000;
   localparam logic [FACTOR_W-1:0] BPM_PER_PEAK_RST = 8'd30;
   localparam logic [BPM_W-1:0] RUN_LOW_BPM_RST = 16'd60;
   localparam logic [BPM_W-1:0] RUN_HIGH_BPM_RST = 16'd240;

   typedef struct packed {
      logic is_eval;
      logic [DIFF_W-1:0] diff;
   } cmd_type;

   typedef struct packed {
      logic [TOTAL_W-1:0] peak_total;
      logic [BPM_W-1:0] cadence_bpm;
      logic is_running;
   } rsp_type;

   typedef struct packed {
      logic [DIFF_W-1:0] peak_threshold;
      logic [FACTOR_W-1:0] bpm_per_peak;
      logic [BPM_W-1:0] run_low_bpm;
      logic [BPM_W-1:0] run_high_bpm;
   } cfg_type;
endpackage
`default_nettype wire

[rtl/scpc_queue.sv]
// Short first-in first-out queue of fixed depth.
`default_nettype none
module scpc_queue
   import scpc_pkg::*;
#(
   parameter int WIDTH = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] head_data
);
   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);

   logic [WIDTH-1:0] slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0] count_ff, count_in;
   logic do_push, do_pop;

   assign full = (count_ff == (PTR_W + 1)'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign do_push = push & ~full;
   assign do_pop = pop & ~empty;
   assign head_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end
endmodule
`default_nettype wire

[rtl/scpc_front.sv]
// Front end: accepts items, forms the sample difference and classifies.
`default_nettype none
module scpc_front
   import scpc_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_push,
   output logic                       req_full,
   input  logic                       req_func,
   input  logic signed [SAMPLE_W-1:0] req_accel_sample,
   input  logic                       queue_full,
   output logic                       queue_push,
   output cmd_type                    queue_data
);
   logic signed [SAMPLE_W-1:0] prev_ff, prev_in;
   logic signed [DIFF_W-1:0] diff;
   logic take;

   assign req_full = queue_full;
   assign take = req_push & ~queue_full;
   assign queue_push = take;
   assign diff = DIFF_W'(req_accel_sample) - DIFF_W'(prev_ff);

   always_comb begin
      queue_data.is_eval = req_func;
      queue_data.diff = diff;
      prev_in = prev_ff;
      if (take && !req_func) begin
         prev_in = req_accel_sample;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= '0;
      end else begin
         prev_ff <= prev_in;
      end
   end
endmodule
`default_nettype wire

[rtl/scpc_back.sv]
// Back end: difference ring memory, window scan and cadence result.
`default_nettype none
module scpc_back
   import scpc_pkg::*;
#(
   parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    cmd_empty,
   input  cmd_type cmd_data,
   output logic    cmd_pop,
   input  logic    rsp_full,
   output logic    rsp_push,
   output rsp_type rsp_data
);
   localparam int PTR_W = $clog2(WINDOW_DEPTH);
   localparam int CNT_W = $clog2(WINDOW_DEPTH);
   localparam int PROD_W = CNT_W + FACTOR_W;
   localparam int PROD_WIDE_W = (PROD_W > BPM_W) ? PROD_W : BPM_W + 1;
   localparam int CNT_WIDE_W = (CNT_W > TOTAL_W) ? CNT_W : TOTAL_W + 1;
   localparam logic [PTR_W-1:0] LAST_ADDR = PTR_W'(WINDOW_DEPTH - 1);
   localparam logic [PTR_W-1:0] LAST_ISSUE = PTR_W'(WINDOW_DEPTH - 3);
   localparam logic [PTR_W:0] FULL_FILL = (PTR_W + 1)'(WINDOW_DEPTH);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SCAN = 3'd1;
   localparam logic [2:0] ST_WAIT = 3'd2;
   localparam logic [2:0] ST_MUL = 3'd3;
   localparam logic [2:0] ST_FIN = 3'd4;

   logic [2:0] state_ff, state_in;
   logic [PTR_W-1:0] wp_ff, wp_in;
   logic [PTR_W:0] fill_ff, fill_in;
   logic [PTR_W-1:0] rd_addr_ff, rd_addr_in;
   logic [PTR_W-1:0] issue_ff, issue_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic signed [DIFF_W-1:0] ring_mem [WINDOW_DEPTH];
   logic signed [DIFF_W-1:0] rd_data_ff;
   logic rd_ok_ff;
   logic rd_vld_ff, rd_last_ff;
   logic signed [DIFF_W-1:0] tap_val, win0_ff, win1_ff;
   logic [1:0] win_vld_ff;
   logic peak_ff, peak_vld_ff, peak_last_ff;
   logic [PROD_W-1:0] prod_ff;
   logic signed [DIFF_W-1:0] threshold;
   logic issuing, start_eval, do_sample;
   logic [PROD_WIDE_W-1:0] prod_wide;
   logic [CNT_WIDE_W-1:0] count_wide;
   logic [BPM_W-1:0] cadence;

   function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] a);
      return (a == LAST_ADDR) ? '0 : a + 1'b1;
   endfunction

   assign threshold = $signed(cfg.peak_threshold);
   assign issuing = (state_ff == ST_SCAN);
   assign start_eval = (state_ff == ST_IDLE) && !cmd_empty && cmd_data.is_eval && !rsp_full;
   assign do_sample = (state_ff == ST_IDLE) && !cmd_empty && !cmd_data.is_eval;
   assign cmd_pop = start_eval | do_sample;
   assign tap_val = rd_ok_ff ? rd_data_ff : '0;

   always_comb begin
      state_in = state_ff;
      wp_in = wp_ff;
      fill_in = fill_ff;
      rd_addr_in = rd_addr_ff;
      issue_in = issue_ff;
      count_in = count_ff;
      if (peak_vld_ff && peak_ff) begin
         count_in = count_ff + 1'b1;
      end
      case (state_ff)
         ST_IDLE: begin
            if (do_sample) begin
               wp_in = wrap_inc(wp_ff);
               fill_in = (fill_ff == FULL_FILL) ? fill_ff : fill_ff + 1'b1;
            end
            if (start_eval) begin
               rd_addr_in = wrap_inc(wp_ff);
               issue_in = '0;
               count_in = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            rd_addr_in = wrap_inc(rd_addr_ff);
            issue_in = issue_ff + 1'b1;
            if (issue_ff == LAST_ISSUE) begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (peak_last_ff) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            state_in = ST_FIN;
         end
         ST_FIN: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         wp_ff <= '0;
         fill_ff <= '0;
         rd_vld_ff <= 1'b0;
         rd_last_ff <= 1'b0;
         win_vld_ff <= '0;
         peak_vld_ff <= 1'b0;
         peak_last_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         wp_ff <= wp_in;
         fill_ff <= fill_in;
         rd_vld_ff <= issuing;
         rd_last_ff <= issuing && (issue_ff == LAST_ISSUE);
         if (start_eval) begin
            win_vld_ff <= '0;
         end else if (rd_vld_ff) begin
            win_vld_ff <= {win_vld_ff[0], 1'b1};
         end
         peak_vld_ff <= rd_vld_ff && (&win_vld_ff);
         peak_last_ff <= rd_last_ff;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_addr_ff <= rd_addr_in;
      issue_ff <= issue_in;
      if (rd_vld_ff) begin
         win0_ff <= win1_ff;
         win1_ff <= tap_val;
      end
      peak_ff <= (win1_ff > threshold) && (win1_ff > win0_ff) && (win1_ff > tap_val);
      if (state_ff == ST_MUL) begin
         prod_ff <= PROD_W'(count_ff) * PROD_W'(cfg.bpm_per_peak);
      end
   end

   // ring memory: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (do_sample) begin
         ring_mem[wp_ff] <= $signed(cmd_data.diff);
      end
      rd_data_ff <= ring_mem[rd_addr_ff];
      rd_ok_ff <= ({1'b0, rd_addr_ff} < fill_ff);
   end

   assign prod_wide = PROD_WIDE_W'(prod_ff);
   assign count_wide = CNT_WIDE_W'(count_ff);
   assign cadence = (prod_wide > PROD_WIDE_W'(BPM_MAX)) ? '1 : BPM_W'(prod_wide);
   assign rsp_push = (state_ff == ST_FIN);

   always_comb begin
      rsp_data.peak_total = (count_wide > CNT_WIDE_W'(TOTAL_MAX)) ? '1 : TOTAL_W'(count_wide);
      rsp_data.cadence_bpm = cadence;
      rsp_data.is_running = (cadence > cfg.run_low_bpm) && (cadence < cfg.run_high_bpm);
   end
endmodule
`default_nettype wire

[rtl/step_cadence_peak_counter_core.sv]
// Step cadence peak counter: a sample item pushes the first difference of a
// vertical acceleration value into a ring of the last WINDOW_DEPTH differences;
// an evaluate item counts strict local maxima above peak_threshold, scales the
// count by bpm_per_peak (saturated at 65535) and flags running when the cadence
// lies strictly between run_low_bpm and run_high_bpm. An evaluate steps the ring
// memory's single read port through one entry per cycle, and the back end takes
// no further item until the evaluate is done. The ring
// needs no clearing pass after reset: a fill count makes unwritten entries
// read as zero. Items queue two deep in front of the back end and results two
// deep behind it, so the input is taken while a result waits to be popped.
`default_nettype none
module step_cadence_peak_counter_core
   import scpc_pkg::*;
#(
   parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_push,
   output logic                         req_full,
   input  logic                         req_func,
   input  logic signed [SAMPLE_W-1:0]   req_accel_sample,
   output logic                         rsp_empty,
   input  logic                         rsp_pop,
   output logic        [TOTAL_W-1:0]    rsp_peak_total,
   output logic        [BPM_W-1:0]      rsp_cadence_bpm,
   output logic                         rsp_is_running,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic        [CSR_IDX_W-1:0]  csr_index,
   input  logic        [CSR_DATA_W-1:0] csr_wdata
);
   cfg_type cfg_ff;
   cmd_type front_cmd, back_cmd;
   rsp_type back_rsp, head_rsp;
   logic cmd_push, cmd_full, cmd_empty, cmd_pop;
   logic rsp_push, rsp_full;
   logic [$bits(cmd_type)-1:0] cmd_head_bits;
   logic [$bits(rsp_type)-1:0] rsp_head_bits;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.peak_threshold <= PEAK_THRESHOLD_RST;
         cfg_ff.bpm_per_peak <= BPM_PER_PEAK_RST;
         cfg_ff.run_low_bpm <= RUN_LOW_BPM_RST;
         cfg_ff.run_high_bpm <= RUN_HIGH_BPM_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_PEAK_THRESHOLD: cfg_ff.peak_threshold <= csr_wdata[DIFF_W-1:0];
            CSR_BPM_PER_PEAK: cfg_ff.bpm_per_peak <= csr_wdata[FACTOR_W-1:0];
            CSR_RUN_LOW_BPM: cfg_ff.run_low_bpm <= csr_wdata[BPM_W-1:0];
            CSR_RUN_HIGH_BPM: cfg_ff.run_high_bpm <= csr_wdata[BPM_W-1:0];
            default: begin
            end
         endcase
      end
   end

   scpc_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_func         (req_func),
      .req_accel_sample (req_accel_sample),
      .queue_full       (cmd_full),
      .queue_push       (cmd_push),
      .queue_data       (front_cmd)
   );

   scpc_queue #(
      .WIDTH ($bits(cmd_type))
   ) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (front_cmd),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .empty     (cmd_empty),
      .head_data (cmd_head_bits)
   );

   assign back_cmd = cmd_type'(cmd_head_bits);

   scpc_back #(
      .WINDOW_DEPTH (WINDOW_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd_empty (cmd_empty),
      .cmd_data  (back_cmd),
      .cmd_pop   (cmd_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp_data  (back_rsp)
   );

   scpc_queue #(
      .WIDTH ($bits(rsp_type))
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (back_rsp),
      .full      (rsp_full),
      .pop       (rsp_pop),
      .empty     (rsp_empty),
      .head_data (rsp_head_bits)
   );

   assign head_rsp = rsp_type'(rsp_head_bits);
   assign rsp_peak_total = head_rsp.peak_total;
   assign rsp_cadence_bpm = head_rsp.cadence_bpm;
   assign rsp_is_running = head_rsp.is_running;
endmodule
`default_nettype wire

[rtl/step_cadence_peak_counter_core_checker.sv]
// Port-level checker for the step cadence peak counter, bound to the top level.
`default_nettype none
`include "step_cadence_peak_counter_core_macros.svh"
module step_cadence_peak_counter_core_checker
   import scpc_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_full,
   input logic                  rsp_empty,
   input logic                  rsp_pop,
   input logic [TOTAL_W-1:0]    rsp_peak_total,
   input logic [BPM_W-1:0]      rsp_cadence_bpm,
   input logic                  rsp_is_running
);
   `SCPC_ASSERT_NEXT(a_reset_drains, clock, 1'b0, reset, rsp_empty && !req_full)
   `SCPC_ASSERT_IMPLY(a_running_has_cadence, clock, reset,
      !rsp_empty && rsp_is_running, rsp_cadence_bpm != '0)
   `SCPC_ASSERT_IMPLY(a_no_peaks_no_cadence, clock, reset,
      !rsp_empty && rsp_peak_total == '0, rsp_cadence_bpm == '0 && !rsp_is_running)
   `SCPC_ASSERT_NEXT(a_result_holds, clock, reset, !rsp_empty && !rsp_pop,
      !rsp_empty && $stable(rsp_peak_total) && $stable(rsp_cadence_bpm)
      && $stable(rsp_is_running))
endmodule

bind step_cadence_peak_counter_core step_cadence_peak_counter_core_checker u_checker (.*);
`default_nettype wire

[dv/tb_step_cadence_peak_counter_core.sv]
// Self-checking testbench for the step cadence peak counter core.
module tb_step_cadence_peak_counter_core;
   import scpc_pkg::*;

   localparam int WINDOW = WINDOW_DEPTH_DEF;
   localparam int SETTLE_CYCLES = 2 * (WINDOW + 3) + 16;
   localparam int PHASE_ITEMS = 120;

   class cadence_scoreboard;
      logic signed [DIFF_W-1:0] threshold;
      logic [FACTOR_W-1:0] factor;
      logic [BPM_W-1:0] low_bpm;
      logic [BPM_W-1:0] high_bpm;
      logic signed [SAMPLE_W-1:0] last_sample;
      logic signed [DIFF_W-1:0] diffs [WINDOW];
      int unsigned head;
      rsp_type expected_reports[$];
      int failures;

      function new();
         threshold = PEAK_THRESHOLD_RST;
         factor = BPM_PER_PEAK_RST;
         low_bpm = RUN_LOW_BPM_RST;
         high_bpm = RUN_HIGH_BPM_RST;
         last_sample = '0;
         head = 0;
         failures = 0;
         foreach (diffs[i]) diffs[i] = '0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_PEAK_THRESHOLD: threshold = data;
            CSR_BPM_PER_PEAK: factor = data[FACTOR_W-1:0];
            CSR_RUN_LOW_BPM: low_bpm = data[BPM_W-1:0];
            CSR_RUN_HIGH_BPM: high_bpm = data[BPM_W-1:0];
            default: ;
         endcase
      endfunction

      function void apply_item(logic is_eval, logic signed [SAMPLE_W-1:0] sample);
         int unsigned peaks;
         int unsigned idx;
         longint unsigned cadence;
         rsp_type report;
         if (!is_eval) begin
            diffs[head] = DIFF_W'(int'(sample) - int'(last_sample));
            last_sample = sample;
            head = (head + 1) % WINDOW;
            return;
         end
         peaks = 0;
         for (int i = 2; i + 2 < WINDOW; i++) begin
            idx = (head + i) % WINDOW;
            if (diffs[idx] > threshold && diffs[idx] > diffs[(idx + WINDOW - 1) % WINDOW]
                && diffs[idx] > diffs[(idx + 1) % WINDOW])
               peaks++;
         end
         cadence = longint'(peaks) * factor;
         if (cadence > BPM_MAX)
            cadence = BPM_MAX;
         report.peak_total = (peaks > TOTAL_MAX) ? TOTAL_W'(TOTAL_MAX) : TOTAL_W'(peaks);
         report.cadence_bpm = cadence[BPM_W-1:0];
         report.is_running = (cadence > low_bpm) && (cadence < high_bpm);
         expected_reports.push_back(report);
      endfunction

      function void check_report(rsp_type got);
         rsp_type want;
         if (expected_reports.size() == 0) begin
            $error("unexpected report: peak_total %0d cadence_bpm %0d is_running %0d",
                   got.peak_total, got.cadence_bpm, got.is_running);
            failures++;
            return;
         end
         want = expected_reports.pop_front();
         if (got.peak_total !== want.peak_total) begin
            $error("peak_total: expected %0d, actual %0d", want.peak_total, got.peak_total);
            failures++;
         end
         if (got.cadence_bpm !== want.cadence_bpm) begin
            $error("cadence_bpm: expected %0d, actual %0d", want.cadence_bpm, got.cadence_bpm);
            failures++;
         end
         if (got.is_running !== want.is_running) begin
            $error("is_running: expected %0d, actual %0d", want.is_running, got.is_running);
            failures++;
         end
      endfunction
   endclass

   logic clock;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   logic req_full;
   logic req_func = 1'b0;
   logic signed [SAMPLE_W-1:0] req_accel_sample = '0;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   logic [TOTAL_W-1:0] rsp_peak_total;
   logic [BPM_W-1:0] rsp_cadence_bpm;
   logic rsp_is_running;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   bit steady = 1'b0;
   int items_sent = 0;
   cadence_scoreboard tracker = new();

   step_cadence_peak_counter_core dut (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_func(req_func),
      .req_accel_sample(req_accel_sample),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_peak_total(rsp_peak_total),
      .rsp_cadence_bpm(rsp_cadence_bpm),
      .rsp_is_running(rsp_is_running),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty)
            tracker.check_report(rsp_type'{peak_total: rsp_peak_total,
                                           cadence_bpm: rsp_cadence_bpm,
                                           is_running: rsp_is_running});
         rsp_pop <= steady || ($urandom_range(99) >= 17);
      end
   end

   task automatic push_item(logic is_eval, logic signed [SAMPLE_W-1:0] sample);
      if (!steady)
         while ($urandom_range(99) < 17) begin
            req_push <= 1'b0;
            @(posedge clock);
         end
      req_push <= 1'b1;
      req_func <= is_eval;
      req_accel_sample <= sample;
      @(posedge clock);
      while (req_full) @(posedge clock);
      tracker.apply_item(is_eval, sample);
      items_sent++;
   endtask

   task automatic settle();
      req_push <= 1'b0;
      while (tracker.expected_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      tracker.write_reg(idx, data);
   endtask

   task automatic configure(logic [CSR_DATA_W-1:0] thr, logic [CSR_DATA_W-1:0] fac,
                            logic [CSR_DATA_W-1:0] lo, logic [CSR_DATA_W-1:0] hi);
      write_csr(CSR_PEAK_THRESHOLD, thr);
      write_csr(CSR_BPM_PER_PEAK, fac);
      write_csr(CSR_RUN_LOW_BPM, lo);
      write_csr(CSR_RUN_HIGH_BPM, hi);
      csr_valid <= 1'b0;
   endtask

   task automatic pick_config();
      int thr;
      int fac;
      int lo;
      int hi;
      logic [31:0] junk;
      thr = int'($urandom_range(0, 9000)) - 2000;
      fac = ($urandom_range(9) == 0) ? 0 : int'($urandom_range(1, 255));
      lo = $urandom_range(0, 300);
      hi = lo + int'($urandom_range(0, 400));
      if ($urandom_range(4) == 0)
         hi = $urandom_range(0, lo);
      junk = $urandom;
      configure(CSR_DATA_W'(thr), {junk[8:0], 8'(fac)}, {junk[9], 16'(lo)},
                {junk[10], 16'(hi)});
   endtask

   task automatic sample_then_maybe_eval(int s);
      push_item(1'b0, SAMPLE_W'(s));
      if ($urandom_range(99) < 6)
         push_item(1'b1, SAMPLE_W'($urandom));
   endtask

   task automatic run_phase(int budget);
      int start;
      int mode;
      int len;
      int period;
      int offset;
      int amp;
      int base;
      int step_size;
      start = items_sent;
      while (items_sent - start < budget) begin
         mode = $urandom_range(99);
         if (mode < 60) begin
            // gait: one spike per stride on a jittery baseline
            len = $urandom_range(20, 220);
            period = $urandom_range(2, 70);
            offset = $urandom_range(0, period - 1);
            amp = $urandom_range(0, 24000);
            base = int'($urandom_range(0, 8000)) - 4000;
            for (int k = 0; k < len && items_sent - start < budget; k++)
               sample_then_maybe_eval(base + int'($urandom_range(0, 40)) - 20
                                      + (((k + offset) % period == 0) ? amp : 0));
         end else if (mode < 75) begin
            // ramp: equal differences, never a strict maximum
            len = $urandom_range(5, 40);
            step_size = int'($urandom_range(0, 1000)) - 500;
            base = int'($urandom_range(0, 20000)) - 10000;
            for (int k = 0; k < len && items_sent - start < budget; k++)
               sample_then_maybe_eval(base + k * step_size);
         end else begin
            len = $urandom_range(1, 30);
            for (int k = 0; k < len && items_sent - start < budget; k++)
               sample_then_maybe_eval(int'($urandom_range(0, 65535)) - 32768);
         end
         push_item(1'b1, SAMPLE_W'($urandom));
         if ($urandom_range(9) == 0)
            push_item(1'b1, SAMPLE_W'($urandom));
      end
   endtask

   initial begin
      int first_samples[8] = '{32767, -32768, 32767, 0, -1, 0, 0, 1000};
      int next_samples[8] = '{0, 0, 1001, 0, 0, 1500, 3000, 4500};
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      push_item(1'b1, 16'sh7FFF);
      foreach (first_samples[i]) push_item(1'b0, SAMPLE_W'(first_samples[i]));
      push_item(1'b1, 16'sh0000);
      foreach (next_samples[i]) push_item(1'b0, SAMPLE_W'(next_samples[i]));
      push_item(1'b0, 16'sh0000);
      push_item(1'b0, 16'sh0000);
      push_item(1'b1, -16'sh8000);
      settle();

      for (int phase = 1; phase <= 7; phase++) begin
         case (phase)
            1: configure(17'h10000, 17'd255, 17'd0, 17'd65535);
            2: configure(17'h0FFFF, 17'd0, 17'd65535, 17'd0);
            3: configure(17'd800, 17'd30, 17'd60, 17'd240);
            default: pick_config();
         endcase
         steady = (phase == 3);
         run_phase(PHASE_ITEMS);
         settle();
      end

      if (tracker.failures == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("FAILURE");
      $finish;
   end
endmodule
